// ===== hw/rtl/dsparse_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal string parser package
// Character codes, field widths and limits shared by the parser and its
// checker.
// ----------------------------------------------------------------------------
package dsparse_pkg;

  localparam int CHAR_W      = 8;
  localparam int MAG_W       = 63;
  localparam int VALUE_W     = 64;
  localparam int OUT_TDATA_W = 2 * VALUE_W;

  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Largest denominator that can still take one more factor of ten.
  localparam logic [VALUE_W-1:0] DEN_MAX   = {VALUE_W{1'b1}};
  localparam logic [VALUE_W-1:0] DEN_LIMIT = DEN_MAX / 64'd10;

  // Failure beat contents.
  localparam logic [VALUE_W-1:0] FAIL_NUMERATOR   = '0;
  localparam logic [VALUE_W-1:0] FAIL_DENOMINATOR = 64'd1;

endpackage

// ===== hw/rtl/decimal_string_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Decimal string parser
// Reads an ASCII decimal number one character per beat and emits a signed
// numerator with its power-of-ten denominator, or a failure, on the last one.
// ----------------------------------------------------------------------------
// Path: a result beat reaches the master side from the last character beat
// through the input register and then the result register.
// Throughput: one character per cycle; the result register stalls the input
// only when a new last character meets a result that has not been taken yet.
// Reset: synchronous, active high; empties both registers and returns the
// parser state to the start of a string.
module decimal_string_parser_unit
  import dsparse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Character stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] char_byte
  input  logic                   s_axis_tlast,   // last_char
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [63:0] numerator,
                                                  // [127:64] denominator_out
  output logic                   m_axis_tuser    // parse_ok
);

  // Input register: one character beat waiting to be applied to the state.
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  // Parser state for the string in progress.
  logic [MAG_W-1:0]   magnitude_acc;
  logic [VALUE_W-1:0] denom_acc;
  logic               point_seen;
  logic               digit_seen;
  logic               sign_negative;
  logic               error_seen;
  logic               at_first_char;

  // Result register.
  logic               out_valid;
  logic               out_ok;
  logic [VALUE_W-1:0] out_numerator;
  logic [VALUE_W-1:0] out_denominator;

  // The held character moves on unless it is a last character that would
  // overwrite a result still waiting on the master side.
  logic advance;
  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Character classes and the multiply-by-ten-add of the magnitude. Both
  // products are formed as shift-add; the magnitude sum keeps four spare
  // bits so that anything above 2^63-1 is seen as overflow.
  logic [CHAR_W-1:0]  char_offset;
  logic [3:0]         digit_val;
  logic               is_digit;
  logic               is_sign;
  logic [MAG_W+3:0]   mag_ext;
  logic [MAG_W+3:0]   mag_sum;
  logic               mag_ovf;
  logic               den_ovf;
  logic [VALUE_W-1:0] den_times10;

  assign char_offset = in_char - CHAR_ZERO;
  assign digit_val   = char_offset[3:0];
  assign is_digit    = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
  assign is_sign     = (in_char == CHAR_MINUS) || (in_char == CHAR_PLUS);
  assign mag_ext     = {4'b0000, magnitude_acc};
  assign mag_sum     = (mag_ext << 3) + (mag_ext << 1) + {{MAG_W{1'b0}}, digit_val};
  assign mag_ovf     = |mag_sum[MAG_W+3:MAG_W];
  assign den_ovf     = denom_acc > DEN_LIMIT;
  assign den_times10 = (denom_acc << 3) + (denom_acc << 1);

  // Next parser state after the held character.
  logic [MAG_W-1:0]   magnitude_acc_next;
  logic [VALUE_W-1:0] denom_acc_next;
  logic               point_seen_next;
  logic               digit_seen_next;
  logic               sign_negative_next;
  logic               error_seen_next;

  always_comb begin
    magnitude_acc_next = magnitude_acc;
    denom_acc_next     = denom_acc;
    point_seen_next    = point_seen;
    digit_seen_next    = digit_seen;
    sign_negative_next = sign_negative;
    error_seen_next    = error_seen;
    if (!error_seen) begin
      if (at_first_char && is_sign) begin
        // A sign is taken only as the very first character.
        sign_negative_next = (in_char == CHAR_MINUS);
      end else if ((in_char == CHAR_POINT) && !point_seen) begin
        point_seen_next = 1'b1;
      end else if (!is_digit) begin
        // Late signs, a second point and every other byte land here.
        error_seen_next = 1'b1;
      end else if (mag_ovf || (point_seen && den_ovf)) begin
        error_seen_next = 1'b1;
      end else begin
        magnitude_acc_next = mag_sum[MAG_W-1:0];
        if (point_seen) begin
          denom_acc_next = den_times10;
        end
        digit_seen_next = 1'b1;
      end
    end
  end

  // Result that the string would give if it ended on the held character.
  logic               result_ok;
  logic [VALUE_W-1:0] result_mag;
  logic [VALUE_W-1:0] result_numerator;

  assign result_ok        = !error_seen_next && digit_seen_next;
  assign result_mag       = {1'b0, magnitude_acc_next};
  // Negating a zero magnitude yields zero, so "-0" needs no special case.
  assign result_numerator = sign_negative_next ? (VALUE_W'(0) - result_mag) : result_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      magnitude_acc <= '0;
      denom_acc     <= VALUE_W'(1);
      point_seen    <= 1'b0;
      digit_seen    <= 1'b0;
      sign_negative <= 1'b0;
      error_seen    <= 1'b0;
      at_first_char <= 1'b1;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
        in_char  <= s_axis_tdata;
        in_last  <= s_axis_tlast;
      end

      if (advance) begin
        if (in_last) begin
          // The string is complete: start over for the next one.
          magnitude_acc <= '0;
          denom_acc     <= VALUE_W'(1);
          point_seen    <= 1'b0;
          digit_seen    <= 1'b0;
          sign_negative <= 1'b0;
          error_seen    <= 1'b0;
          at_first_char <= 1'b1;
        end else begin
          magnitude_acc <= magnitude_acc_next;
          denom_acc     <= denom_acc_next;
          point_seen    <= point_seen_next;
          digit_seen    <= digit_seen_next;
          sign_negative <= sign_negative_next;
          error_seen    <= error_seen_next;
          at_first_char <= 1'b0;
        end
      end

      if (advance && in_last) begin
        out_valid <= 1'b1;
        out_ok    <= result_ok;
        if (result_ok) begin
          out_numerator   <= result_numerator;
          out_denominator <= denom_acc_next;
        end else begin
          out_numerator   <= FAIL_NUMERATOR;
          out_denominator <= FAIL_DENOMINATOR;
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_denominator, out_numerator};
  assign m_axis_tuser  = out_ok;

endmodule

// ===== hw/rtl/dsparse_checker.sv =====
// ----------------------------------------------------------------------------
// Decimal string parser checker
// Port-level assertions on the character and result streams, bound to the parser unit.
// ----------------------------------------------------------------------------
module dsparse_checker
  import dsparse_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [CHAR_W-1:0]      s_axis_tdata,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // An offered character beat that is not taken stays on the bus unchanged.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
    else $error("character beat changed while stalled");

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A failure carries numerator zero and denominator one.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[VALUE_W-1:0] == FAIL_NUMERATOR &&
      m_axis_tdata[OUT_TDATA_W-1:VALUE_W] == FAIL_DENOMINATOR)
    else $error("failure beat with nonzero payload");

  // A good result never has a zero denominator nor the most negative numerator.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[OUT_TDATA_W-1:VALUE_W] != '0 &&
      m_axis_tdata[VALUE_W-1:0] != {1'b1, {(VALUE_W-1){1'b0}}})
    else $error("good result out of range");

endmodule

bind decimal_string_parser_unit dsparse_checker u_dsparse_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal string parser testbench
// Streams ASCII number strings into the parser one character beat at a time.
// A local model predicts each result beat, and the result beats are checked
// in order. Directed strings cover signs, points, bad bytes and both overflow
// limits. Random strings follow: mostly well-formed numbers, some broken ones
// and some noise. Both sides idle at random, and one long receiver hold-off
// backs the parser up.
// ----------------------------------------------------------------------------
module tb
  import dsparse_pkg::*;
();

  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TOTAL_CHARS  = 1100;

  // Largest magnitude that fits in a signed 64-bit numerator.
  localparam logic [VALUE_W-1:0] MAG_LIMIT = {1'b0, {MAG_W{1'b1}}};

  typedef struct {
    logic               ok;
    logic [VALUE_W-1:0] numerator;
    logic [VALUE_W-1:0] denominator;
  } parse_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [CHAR_W-1:0]      s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // Results predicted for strings whose last beat has been accepted.
  parse_result_t parsed_values[$];
  // Characters of the next string to send.
  logic [CHAR_W-1:0] draft[$];

  int fail_count  = 0;
  int chars_sent  = 0;
  int cycle_count = 0;
  bit no_idle      = 1'b0;
  bit hold_results = 1'b0;

  // State of the string being parsed, as the block should hold it.
  logic [MAG_W-1:0]   num_mag;
  logic [VALUE_W-1:0] num_den;
  logic               num_point;
  logic               num_digit;
  logic               num_negative;
  logic               num_error;
  logic               num_first;

  decimal_string_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  task automatic clear_number();
    num_mag      = '0;
    num_den      = 64'd1;
    num_point    = 1'b0;
    num_digit    = 1'b0;
    num_negative = 1'b0;
    num_error    = 1'b0;
    num_first    = 1'b1;
  endtask

  // Folds one accepted character into the number and, on the last one,
  // queues the result the block must produce.
  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last_char);
    logic               first_char;
    logic [VALUE_W-1:0] digit;
    logic [VALUE_W-1:0] wide;
    parse_result_t      res;
    first_char = num_first;
    num_first  = 1'b0;
    if (!num_error) begin
      if (first_char && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
        num_negative = (c == CHAR_MINUS);
      end else if (c == CHAR_POINT && !num_point) begin
        num_point = 1'b1;
      end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
        num_error = 1'b1;
      end else begin
        digit = 64'(c) - 64'(CHAR_ZERO);
        wide  = {1'b0, num_mag};
        if (wide > (MAG_LIMIT - digit) / 64'd10) begin
          num_error = 1'b1;
        end else if (num_point && num_den > DEN_LIMIT) begin
          num_error = 1'b1;
        end else begin
          wide    = wide * 64'd10 + digit;
          num_mag = wide[MAG_W-1:0];
          if (num_point) num_den = num_den * 64'd10;
          num_digit = 1'b1;
        end
      end
    end
    if (last_char) begin
      if (!num_error && num_digit) begin
        res.ok          = 1'b1;
        res.numerator   = num_negative ? -{1'b0, num_mag} : {1'b0, num_mag};
        res.denominator = num_den;
      end else begin
        res.ok          = 1'b0;
        res.numerator   = FAIL_NUMERATOR;
        res.denominator = FAIL_DENOMINATOR;
      end
      parsed_values.insert(parsed_values.size(), res);
      clear_number();
    end
  endtask

  // Prediction and checking share one process so that a beat in and a beat
  // out at the same edge are handled in a fixed order.
  always @(posedge clk) begin : result_check
    parse_result_t      want;
    logic [VALUE_W-1:0] got_num;
    logic [VALUE_W-1:0] got_den;
    if (rst) begin
      clear_number();
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got_num = m_axis_tdata[VALUE_W-1:0];
        got_den = m_axis_tdata[OUT_TDATA_W-1:VALUE_W];
        if (parsed_values.size() == 0) begin
          $error("result beat with no string pending: ok %0b numerator %0d",
                 m_axis_tuser, $signed(got_num));
          fail_count++;
        end else begin
          want = parsed_values.pop_front();
          if (m_axis_tuser !== want.ok) begin
            $error("parse_ok: expected %0b, got %0b", want.ok, m_axis_tuser);
            fail_count++;
          end
          if (got_num !== want.numerator) begin
            $error("numerator: expected %0d, got %0d",
                   $signed(want.numerator), $signed(got_num));
            fail_count++;
          end
          if (got_den !== want.denominator) begin
            $error("denominator_out: expected %0d, got %0d", want.denominator, got_den);
            fail_count++;
          end
        end
      end
    end
  end

  // Result side: a random stall before each beat, and one long hold-off on
  // request while the character side keeps offering beats.
  initial begin : result_taker
    int stall;
    @(negedge clk);
    forever begin
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready) && !hold_results);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("CHECK FAILED");
    $finish;
  end

  // Sends one character beat. Called and returns at a falling edge; valid
  // stays high after the beat so back-to-back beats need no extra step.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last_char);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last_char;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_draft();
    for (int i = 0; i < draft.size(); i++) send_char(draft[i], i == draft.size() - 1);
  endtask

  // Adds one character at the end of the string being built.
  task automatic append_char(input logic [CHAR_W-1:0] c);
    draft.insert(draft.size(), c);
  endtask

  task automatic push_digits(input int count);
    repeat (count) append_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // A well-formed number with random sign, length and point position. Some
  // sit right at the magnitude limit and some carry long fractions.
  task automatic build_number();
    int    kind;
    int    sign;
    int    ndig;
    int    point_at;
    string near_max;
    near_max = "922337203685477580";
    draft.delete();
    sign = $urandom_range(0, 5);
    if (sign < 2) append_char(CHAR_MINUS);
    else if (sign == 2) append_char(CHAR_PLUS);
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      for (int i = 0; i < near_max.len(); i++) append_char(near_max[i]);
      push_digits($urandom_range(1, 2));
    end else if (kind == 9) begin
      append_char(CHAR_ZERO);
      append_char(CHAR_POINT);
      push_digits($urandom_range(16, 21));
    end else begin
      ndig     = (kind == 7) ? $urandom_range(9, 19) : $urandom_range(1, 8);
      point_at = $urandom_range(0, 1) ? $urandom_range(0, ndig) : -1;
      for (int i = 0; i <= ndig; i++) begin
        if (i == point_at) append_char(CHAR_POINT);
        if (i < ndig) push_digits(1);
      end
    end
  endtask

  // A number with one character replaced or inserted: a stray sign, an
  // extra point or any byte at all.
  task automatic build_broken_number();
    int                pos;
    logic [CHAR_W-1:0] junk;
    build_number();
    case ($urandom_range(0, 3))
      0:       junk = 8'($urandom_range(0, 255));
      1:       junk = CHAR_POINT;
      2:       junk = CHAR_MINUS;
      default: junk = CHAR_PLUS;
    endcase
    pos = $urandom_range(0, draft.size() - 1);
    if ($urandom_range(0, 1)) draft[pos] = junk;
    else draft.insert(pos, junk);
  endtask

  task automatic build_noise();
    draft.delete();
    repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(0, 255)));
  endtask

  task automatic test_signs_and_points();
    send_text("0");
    send_text("-0");
    send_text("+7");
    send_text("-.5");
    send_text("4.");
    send_text(".");
    send_text("-");
    send_text("+.");
  endtask

  task automatic test_bad_characters();
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("/");
    send_text(":");
    send_text("1x3");
    send_text("1-2");
    send_text("--1");
    send_text("12+");
    send_text("1.2.3");
  endtask

  // Magnitude right at and just past 2^63-1, and denominators of ten to the
  // 19th (fits) and ten to the 20th (does not).
  task automatic test_limits();
    send_text("9223372036854775807");
    send_text("-9223372036854775807");
    send_text("9223372036854775808");
    send_text("92233720368547758070");
    send_text("922337203685477580.7");
    send_text({"0.", "000000000", "000000000", "1"});
    send_text({"-0.", "000000000", "000000000", "01"});
    send_text({"000000000", "000000000", "0000042"});
  endtask

  // The receiver stops for a long stretch while single-digit strings keep
  // coming, so both registers fill and the character side must stall.
  task automatic test_back_pressure();
    hold_results = 1'b1;
    repeat (24) send_char(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b1);
  endtask

  task automatic test_full_rate();
    no_idle = 1'b1;
    repeat (30) begin
      build_number();
      send_draft();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_strings();
    int pick;
    while (chars_sent < TOTAL_CHARS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) build_number();
      else if (pick < 90) build_broken_number();
      else build_noise();
      send_draft();
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_signs_and_points();
    test_bad_characters();
    test_limits();
    test_back_pressure();
    test_full_rate();
    test_random_strings();
    s_axis_tvalid <= 1'b0;
    while (parsed_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
